// ===== sv/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the streaming UTF-8 scalar decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int unsigned MaxResults = 4;

    localparam logic [7:0]  ContMask    = 8'hC0;
    localparam logic [7:0]  ContTag     = 8'h80;
    localparam logic [7:0]  Lead2Lo     = 8'hC2;
    localparam logic [7:0]  Lead2Hi     = 8'hDF;
    localparam logic [7:0]  Lead3Lo     = 8'hE0;
    localparam logic [7:0]  Lead3Hi     = 8'hEF;
    localparam logic [7:0]  Lead4Lo     = 8'hF0;
    localparam logic [7:0]  Lead4Hi     = 8'hF4;
    localparam logic [7:0]  Lead2Mask   = 8'h1F;
    localparam logic [7:0]  Lead3Mask   = 8'h0F;
    localparam logic [7:0]  Lead4Mask   = 8'h07;
    localparam logic [7:0]  PayloadMask = 8'h3F;
    localparam logic [20:0] Min3Byte    = 21'h000800;
    localparam logic [20:0] Min4Byte    = 21'h010000;
    localparam logic [20:0] SurrLo      = 21'h00D800;
    localparam logic [20:0] SurrHi      = 21'h00DFFF;

    localparam logic [2:0]  LenNone = 3'd0;
    localparam logic [2:0]  LenOne  = 3'd1;
    localparam logic [2:0]  LenTwo  = 3'd2;
    localparam logic [2:0]  LenThree = 3'd3;
    localparam logic [2:0]  LenFour = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  byte_count;
        logic [1:0]  utf16_units;
        logic        fell_back;
        logic        run_last;
        logic        text_done;
    } t_out_item;

    // all results caused by one input item
    typedef struct packed {
        t_out_item [MaxResults-1:0] items;
        logic [2:0]                 count;
    } t_group;

    function automatic t_out_item mk_item(logic [20:0] cp, logic [2:0] cnt, logic fb);
        t_out_item r;
        r.code_point  = cp;
        r.byte_count  = cnt;
        r.utf16_units = (cnt == LenFour) ? 2'd2 : 2'd1;
        r.fell_back   = fb;
        r.run_last    = 1'b0;
        r.text_done   = 1'b0;
        return r;
    endfunction

endpackage

// ===== sv/utf8_scalar_decoder.sv =====
// an accepted byte passes the input register, then the result register, before its first result is on the output
// throughput: one byte per cycle while each byte gives at most one result and the output is not stalled;
//   a byte that gives n results (up to 4, on a failed sequence) holds input until its last result leaves
// the rate is set by the result register, which sends one result per cycle while the output is not stalled
// reset: synchronous active low, clears sequence state and empties both registers
// ----------------------------------------------------------------------------
// utf8_scalar_decoder
// Streaming UTF-8 decoder: one byte in, decoded scalars or fallback bytes out.
// ----------------------------------------------------------------------------
module utf8_scalar_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  utf8d_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output utf8d_pkg::t_out_item o_out_item
);

    logic                r_in_valid;
    utf8d_pkg::t_in_item r_in;
    utf8d_pkg::t_group   grp;
    logic                free;
    logic                consume;

    assign consume    = r_in_valid && free;
    assign o_in_stall = r_in_valid && !free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    utf8d_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (consume),
        .i_item  (r_in),
        .o_group (grp)
    );

    utf8d_burst u_burst (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (consume),
        .i_group (grp),
        .o_free  (free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule

// ===== sv/utf8d_step.sv =====
// ----------------------------------------------------------------------------
// utf8d_step
// Sequence state and single-pass decode of one byte into up to four results.
// ----------------------------------------------------------------------------
module utf8d_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  utf8d_pkg::t_in_item i_item,
    output utf8d_pkg::t_group   o_group
);

    logic [7:0]  r_lead, n_lead;
    logic [20:0] r_acc, n_acc;
    logic [2:0]  r_exp, n_exp;
    logic [1:0]  r_hc, n_hc;
    logic [7:0]  r_held [0:2];

    logic [7:0]  view [0:2];
    logic        wr_en;
    logic        used;
    logic        fail1;
    logic        ok;
    logic [1:0]  fhc;
    logic [2:0]  n;
    logic [7:0]  b;
    logic        eot;
    utf8d_pkg::t_out_item [utf8d_pkg::MaxResults-1:0] items;

    assign b   = i_item.in_byte;
    assign eot = i_item.end_of_text;

    always_comb begin
        items  = '0;
        n      = '0;
        n_lead = r_lead;
        n_acc  = r_acc;
        n_exp  = r_exp;
        n_hc   = r_hc;
        used   = 1'b0;
        wr_en  = 1'b0;
        fail1  = 1'b0;
        ok     = 1'b1;
        fhc    = r_hc;
        for (int i = 0; i < 3; i++) begin
            view[i] = r_held[i];
        end

        if (r_exp != utf8d_pkg::LenNone) begin
            if ((b & utf8d_pkg::ContMask) == utf8d_pkg::ContTag) begin
                wr_en = 1'b1;
                if (r_hc != 2'd3) begin
                    view[r_hc] = b;
                end
                n_hc  = r_hc + 2'd1;
                n_acc = {r_acc[14:0], b[5:0]};
                used  = 1'b1;
                if (({1'b0, n_hc} + 3'd1) >= r_exp) begin
                    if (r_exp == utf8d_pkg::LenThree && n_acc < utf8d_pkg::Min3Byte) ok = 1'b0;
                    if (r_exp == utf8d_pkg::LenFour && n_acc < utf8d_pkg::Min4Byte) ok = 1'b0;
                    if (n_acc >= utf8d_pkg::SurrLo && n_acc <= utf8d_pkg::SurrHi) ok = 1'b0;
                    if (ok) begin
                        items[n[1:0]] = utf8d_pkg::mk_item(n_acc, r_exp, 1'b0);
                        n = n + 3'd1;
                        n_lead = '0;
                        n_acc  = '0;
                        n_exp  = utf8d_pkg::LenNone;
                        n_hc   = '0;
                    end else begin
                        fail1 = 1'b1;
                        fhc   = n_hc;
                    end
                end
            end else begin
                fail1 = 1'b1;
                fhc   = r_hc;
            end
        end

        // failed sequence: lead alone, then the held continuation bytes
        if (fail1) begin
            items[n[1:0]] = utf8d_pkg::mk_item({13'd0, r_lead}, utf8d_pkg::LenOne, 1'b1);
            n = n + 3'd1;
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < fhc && n != 3'd4) begin
                    items[n[1:0]] = utf8d_pkg::mk_item({13'd0, view[i]}, utf8d_pkg::LenOne, 1'b0);
                    n = n + 3'd1;
                end
            end
            n_lead = '0;
            n_acc  = '0;
            n_exp  = utf8d_pkg::LenNone;
            n_hc   = '0;
        end

        if (!used) begin
            if (b >= utf8d_pkg::Lead2Lo && b <= utf8d_pkg::Lead2Hi) begin
                n_lead = b;
                n_acc  = {13'd0, b & utf8d_pkg::Lead2Mask};
                n_exp  = utf8d_pkg::LenTwo;
                n_hc   = '0;
            end else if (b >= utf8d_pkg::Lead3Lo && b <= utf8d_pkg::Lead3Hi) begin
                n_lead = b;
                n_acc  = {13'd0, b & utf8d_pkg::Lead3Mask};
                n_exp  = utf8d_pkg::LenThree;
                n_hc   = '0;
            end else if (b >= utf8d_pkg::Lead4Lo && b <= utf8d_pkg::Lead4Hi) begin
                n_lead = b;
                n_acc  = {13'd0, b & utf8d_pkg::Lead4Mask};
                n_exp  = utf8d_pkg::LenFour;
                n_hc   = '0;
            end else if (n != 3'd4) begin
                items[n[1:0]] = utf8d_pkg::mk_item({13'd0, b}, utf8d_pkg::LenOne, 1'b0);
                n = n + 3'd1;
            end
        end

        // text ends inside a sequence: flush it
        if (eot && n_exp != utf8d_pkg::LenNone) begin
            if (n != 3'd4) begin
                items[n[1:0]] = utf8d_pkg::mk_item({13'd0, n_lead}, utf8d_pkg::LenOne, 1'b1);
                n = n + 3'd1;
            end
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < n_hc && n != 3'd4) begin
                    items[n[1:0]] = utf8d_pkg::mk_item({13'd0, view[i]}, utf8d_pkg::LenOne, 1'b0);
                    n = n + 3'd1;
                end
            end
        end
        if (eot) begin
            n_lead = '0;
            n_acc  = '0;
            n_exp  = utf8d_pkg::LenNone;
            n_hc   = '0;
        end

        if (n != 3'd0) begin
            items[n[1:0] - 2'd1].run_last  = 1'b1;
            items[n[1:0] - 2'd1].text_done = eot;
        end
    end

    assign o_group.items = items;
    assign o_group.count = n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= '0;
            r_acc  <= '0;
            r_exp  <= utf8d_pkg::LenNone;
            r_hc   <= '0;
        end else if (i_en) begin
            r_lead <= n_lead;
            r_acc  <= n_acc;
            r_exp  <= n_exp;
            r_hc   <= n_hc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && wr_en && r_hc != 2'd3) begin
            r_held[r_hc] <= b;
        end
    end

endmodule

// ===== sv/utf8d_burst.sv =====
// ----------------------------------------------------------------------------
// utf8d_burst
// Result register that holds one item's results and hands them out in order.
// ----------------------------------------------------------------------------
module utf8d_burst (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  utf8d_pkg::t_group    i_group,
    output logic                 o_free,
    output logic                 o_valid,
    input  logic                 i_stall,
    output utf8d_pkg::t_out_item o_item
);

    utf8d_pkg::t_out_item [utf8d_pkg::MaxResults-1:0] r_items;
    logic [2:0] r_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 3'd0);
    assign pop     = o_valid && !i_stall;
    // free when empty or the last held result leaves this cycle
    assign o_free  = (r_cnt == 3'd0) || (r_cnt == 3'd1 && pop);
    assign o_item  = r_items[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_group.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_items <= i_group.items;
        end else if (pop) begin
            for (int i = 0; i < utf8d_pkg::MaxResults - 1; i++) begin
                r_items[i] <= r_items[i+1];
            end
        end
    end

endmodule

// ===== sv/utf8d_checker.sv =====
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks on the decoder's result stream.
// ----------------------------------------------------------------------------
module utf8d_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input utf8d_pkg::t_out_item o_out_item
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // the rest of a burst follows without a gap
    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_item.run_last |=> o_out_valid)
        else $error("gap inside a result burst");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.text_done |-> o_out_item.run_last)
        else $error("text end not on last result of its item");

    // a fallback result is always a lone lead byte
    a_fallback_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.fell_back |->
            o_out_item.byte_count == utf8d_pkg::LenOne &&
            o_out_item.code_point[20:8] == 13'd0 &&
            o_out_item.code_point[7:0] >= utf8d_pkg::Lead2Lo &&
            o_out_item.code_point[7:0] <= utf8d_pkg::Lead4Hi)
        else $error("bad fallback result");

    a_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.utf16_units == 2'd2) ==
            (o_out_item.byte_count == utf8d_pkg::LenFour))
        else $error("utf16 unit count mismatch");

endmodule

bind utf8_scalar_decoder utf8d_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// ===== verif/tb_utf8_scalar_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_scalar_decoder
// Feeds byte streams split into texts through the decoder and checks every
// scalar it returns against a cycle-free decode kept in the testbench:
// edge cases first, then random texts of mostly well-formed sequences under
// three mixes of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_utf8_scalar_decoder;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    utf8d_pkg::t_in_item  i_in_item;
    logic                 o_out_valid;
    logic                 i_out_stall;
    utf8d_pkg::t_out_item o_out_item;

    utf8_scalar_decoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // decoder state as the testbench sees it
    logic [7:0]  sq_lead;
    logic [20:0] sq_acc;
    logic [2:0]  sq_len;
    int          sq_held;
    logic [7:0]  sq_cont [3];

    utf8d_pkg::t_out_item step_q[$];
    utf8d_pkg::t_out_item pending_scalars[$];
    utf8d_pkg::t_in_item  byte_q[$];
    logic [7:0]           text_q[$];

    bit                   in_taken;
    int                   tx_idle_pct;
    int                   rx_stall_pct;
    int                   err_count;
    int                   n_bytes;
    int                   n_texts;
    int                   n_scalars;
    int                   n_fallbacks;
    utf8d_pkg::t_out_item want;

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // decode prediction
    // ------------------------------------------------------------------------
    task automatic emit(input logic [20:0] cp, input logic [2:0] cnt, input logic fb);
        utf8d_pkg::t_out_item r;
        r             = '0;
        r.code_point  = cp;
        r.byte_count  = cnt;
        r.utf16_units = (cnt == utf8d_pkg::LenFour) ? 2'd2 : 2'd1;
        r.fell_back   = fb;
        step_q.push_back(r);
    endtask

    task automatic drop_seq();
        sq_lead = '0;
        sq_acc  = '0;
        sq_len  = utf8d_pkg::LenNone;
        sq_held = 0;
    endtask

    // lead goes out alone, then each held continuation byte
    task automatic abandon_seq();
        int i;
        emit({13'd0, sq_lead}, utf8d_pkg::LenOne, 1'b1);
        for (i = 0; i < sq_held; i++) begin
            emit({13'd0, sq_cont[i]}, utf8d_pkg::LenOne, 1'b0);
        end
        drop_seq();
    endtask

    task automatic decode_byte(input utf8d_pkg::t_in_item it);
        logic [7:0]           b;
        logic                 took;
        logic                 good;
        utf8d_pkg::t_out_item r;
        int                   i;
        b    = it.in_byte;
        took = 1'b0;
        step_q.delete();
        n_bytes++;
        if (sq_len != utf8d_pkg::LenNone) begin
            if ((b & utf8d_pkg::ContMask) == utf8d_pkg::ContTag) begin
                sq_cont[sq_held] = b;
                sq_held++;
                sq_acc = {sq_acc[14:0], b[5:0]};
                took   = 1'b1;
                if (sq_held + 1 >= sq_len) begin
                    good = 1'b1;
                    if (sq_len == utf8d_pkg::LenThree && sq_acc < utf8d_pkg::Min3Byte)
                        good = 1'b0;
                    if (sq_len == utf8d_pkg::LenFour && sq_acc < utf8d_pkg::Min4Byte)
                        good = 1'b0;
                    if (sq_acc >= utf8d_pkg::SurrLo && sq_acc <= utf8d_pkg::SurrHi)
                        good = 1'b0;
                    if (good) begin
                        emit(sq_acc, sq_len, 1'b0);
                        drop_seq();
                    end else begin
                        abandon_seq();
                    end
                end
            end else begin
                abandon_seq();
            end
        end
        if (!took) begin
            if (b >= utf8d_pkg::Lead2Lo && b <= utf8d_pkg::Lead2Hi) begin
                sq_lead = b;
                sq_acc  = {13'd0, b & utf8d_pkg::Lead2Mask};
                sq_len  = utf8d_pkg::LenTwo;
                sq_held = 0;
            end else if (b >= utf8d_pkg::Lead3Lo && b <= utf8d_pkg::Lead3Hi) begin
                sq_lead = b;
                sq_acc  = {13'd0, b & utf8d_pkg::Lead3Mask};
                sq_len  = utf8d_pkg::LenThree;
                sq_held = 0;
            end else if (b >= utf8d_pkg::Lead4Lo && b <= utf8d_pkg::Lead4Hi) begin
                sq_lead = b;
                sq_acc  = {13'd0, b & utf8d_pkg::Lead4Mask};
                sq_len  = utf8d_pkg::LenFour;
                sq_held = 0;
            end else begin
                emit({13'd0, b}, utf8d_pkg::LenOne, 1'b0);
            end
        end
        if (it.end_of_text) begin
            if (sq_len != utf8d_pkg::LenNone) abandon_seq();
            drop_seq();
            n_texts++;
        end
        for (i = 0; i < step_q.size(); i++) begin
            r = step_q[i];
            if (i == step_q.size() - 1) begin
                r.run_last  = 1'b1;
                r.text_done = it.end_of_text;
            end
            pending_scalars.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------------
    // encode cp in len bytes (overlong if cp is small), keep only the first keep
    task automatic add_seq(input logic [20:0] cp, input int len, input int keep);
        logic [7:0] b [4];
        int         i;
        case (len)
            1: begin
                b[0] = cp[7:0];
            end
            2: begin
                b[0] = {3'b110, cp[10:6]};
                b[1] = {2'b10, cp[5:0]};
            end
            3: begin
                b[0] = {4'b1110, cp[15:12]};
                b[1] = {2'b10, cp[11:6]};
                b[2] = {2'b10, cp[5:0]};
            end
            default: begin
                b[0] = {5'b11110, cp[20:18]};
                b[1] = {2'b10, cp[17:12]};
                b[2] = {2'b10, cp[11:6]};
                b[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (i = 0; i < keep; i++) begin
            text_q.push_back(b[i]);
        end
    endtask

    task automatic end_text();
        utf8d_pkg::t_in_item it;
        int                  i;
        for (i = 0; i < text_q.size(); i++) begin
            it.in_byte     = text_q[i];
            it.end_of_text = (i == text_q.size() - 1);
            byte_q.push_back(it);
        end
        text_q.delete();
    endtask

    function automatic logic [20:0] rand_scalar(input int len);
        logic [20:0] cp;
        case (len)
            2: cp = 21'($urandom_range(21'h7FF, 21'h80));
            3: begin
                cp = 21'($urandom_range(21'hFFFF, 21'h800));
                if (cp >= utf8d_pkg::SurrLo && cp <= utf8d_pkg::SurrHi) cp = cp ^ 21'h2000;
            end
            default: cp = 21'($urandom_range(21'h13FFFF, 21'h10000));
        endcase
        return cp;
    endfunction

    task automatic gen_texts(input int target);
        int added;
        int n;
        int k;
        int r;
        int len;
        added = 0;
        while (added < target) begin
            n = $urandom_range(12, 1);
            for (k = 0; k < n; k++) begin
                r = $urandom_range(99);
                if (r < 30) begin
                    add_seq(21'($urandom_range(127)), 1, 1);
                end else if (r < 72) begin
                    len = (r < 45) ? 2 : (r < 60) ? 3 : 4;
                    add_seq(rand_scalar(len), len, len);
                end else if (r < 80) begin
                    // sequence cut short, next byte breaks it or the text ends
                    len = $urandom_range(4, 2);
                    add_seq(rand_scalar(len), len, $urandom_range(len - 1, 1));
                end else if (r < 86) begin
                    if ($urandom_range(1)) add_seq(21'($urandom_range(21'h7FF, 0)), 3, 3);
                    else add_seq(21'($urandom_range(21'hFFFF, 0)), 4, 4);
                end else if (r < 90) begin
                    add_seq(21'($urandom_range(21'hDFFF, 21'hD800)), 3, 3);
                end else begin
                    add_seq(21'($urandom_range(255)), 1, 1);
                end
            end
            added += text_q.size();
            end_text();
        end
    endtask

    task automatic wait_drained();
        while (byte_q.size() != 0 || i_in_valid || pending_scalars.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: inputs change on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
            if (!i_in_valid || in_taken) begin
                in_taken = 1'b0;
                if (byte_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_in_item  <= byte_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: results checked before the new byte is decoded
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_scalars.size() == 0) begin
                    if (err_count < 10) begin
                        $display("unexpected scalar cp=%h cnt=%0d at %0t",
                                 o_out_item.code_point, o_out_item.byte_count, $realtime);
                    end
                    err_count++;
                end else begin
                    want = pending_scalars.pop_front();
                    n_scalars++;
                    if (want.fell_back) n_fallbacks++;
                    if (o_out_item.code_point !== want.code_point ||
                        o_out_item.byte_count !== want.byte_count ||
                        o_out_item.utf16_units !== want.utf16_units ||
                        o_out_item.fell_back !== want.fell_back ||
                        o_out_item.run_last !== want.run_last ||
                        o_out_item.text_done !== want.text_done) begin
                        if (err_count < 10) begin
                            $display({"mismatch at %0t: got cp=%h cnt=%0d u16=%0d",
                                      " fb=%b last=%b done=%b"},
                                     $realtime, o_out_item.code_point, o_out_item.byte_count,
                                     o_out_item.utf16_units, o_out_item.fell_back,
                                     o_out_item.run_last, o_out_item.text_done);
                            $display("    want cp=%h cnt=%0d u16=%0d fb=%b last=%b done=%b",
                                     want.code_point, want.byte_count, want.utf16_units,
                                     want.fell_back, want.run_last, want.text_done);
                        end
                        err_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                decode_byte(i_in_item);
                in_taken = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequence of phases
    // ------------------------------------------------------------------------
    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_item    = '0;
        i_out_stall  = 1'b0;
        in_taken     = 1'b0;
        tx_idle_pct  = 8;
        rx_stall_pct = 62;
        err_count    = 0;
        n_bytes      = 0;
        n_texts      = 0;
        n_scalars    = 0;
        n_fallbacks  = 0;
        drop_seq();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // edge cases: ascii limits, stray continuation, bad lead, largest 2-byte,
        // surrogate, top scalar, overlong 4-byte, broken 3-byte, above 10FFFF
        add_seq(21'h00, 1, 1);
        add_seq(21'h7F, 1, 1);
        add_seq(21'h80, 1, 1);
        add_seq(21'hFF, 1, 1);
        add_seq(21'h7FF, 2, 2);
        add_seq(21'hD800, 3, 3);
        add_seq(21'h10FFFF, 4, 4);
        add_seq(21'h0, 4, 4);
        add_seq(21'h1000, 3, 1);
        add_seq(21'h41, 1, 1);
        add_seq(21'h110000, 4, 4);
        end_text();
        // text ends in the middle of a sequence
        add_seq(21'h2080, 3, 2);
        end_text();
        // hold off until the directed part has fully drained
        wait_drained();

        gen_texts(120);
        wait_drained();

        tx_idle_pct  = 62;
        rx_stall_pct = 8;
        gen_texts(120);
        wait_drained();

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        gen_texts(110);
        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("summary: %0d bytes in %0d texts, %0d scalars checked, %0d fallback leads",
                 n_bytes, n_texts, n_scalars, n_fallbacks);
        $display("summary: edge cases, then random texts with idle/stall mixes 8/62, 62/8, 0/0");
        if (err_count == 0) begin
            $display("tb_utf8_scalar_decoder: done, clean");
        end else begin
            $display("tb_utf8_scalar_decoder: done, errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_utf8_scalar_decoder: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/utf8d_pkg.sv
sv/utf8d_step.sv
sv/utf8d_burst.sv
sv/utf8_scalar_decoder.sv
sv/utf8d_checker.sv
verif/tb_utf8_scalar_decoder.sv
